>>> hw/rtl/rpdt_pkg.sv
// ---------------------------------------------------------------------------
// rpdt_pkg
// Shared types, codes and microcode store for the receive port dispatch table.
// ---------------------------------------------------------------------------
package rpdt_pkg;

	localparam int ENTRIES = 12;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SLOT_W  = 4;

	localparam logic [1:0] OP_REGISTER   = 2'd0;
	localparam logic [1:0] OP_DEREGISTER = 2'd1;
	localparam logic [1:0] OP_DELIVER    = 2'd2;
	localparam logic [1:0] OP_NONE       = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOMATCH = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] port;
		logic [7:0]  max_length;
		logic        wants_info;
		logic        has_handler;
		logic [7:0]  packet_length;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        copy_length;
		logic              write_info;
		logic              post_handler;
	} rsp_t;

	// search outcome captured by the table
	typedef struct packed {
		logic       free_ok;
		idx_t       free_idx;
		logic       hit_ok;
		idx_t       hit_idx;
		logic [7:0] hit_max;
		logic       hit_info;
		logic       hit_hdl;
	} look_t;

	// microcode
	typedef logic [1:0] step_t;

	localparam step_t STEP_IDLE   = 2'd0;
	localparam step_t STEP_LOOK   = 2'd1;
	localparam step_t STEP_UPDATE = 2'd2;

	typedef enum logic [1:0] {
		JC_NEXT,
		JC_START,
		JC_NOP,
		JC_ALWAYS
	} jc_t;

	typedef struct packed {
		logic  accept;
		logic  look;
		logic  update;
		logic  emit;
		jc_t   jc;
		step_t target;
	} ctl_word_t;

	function automatic ctl_word_t ucode_rom(input step_t s);
		ctl_word_t w;
		w = '{accept: 1'b0, look: 1'b0, update: 1'b0, emit: 1'b0,
			jc: JC_ALWAYS, target: STEP_IDLE};
		case (s)
			STEP_IDLE: begin
				w.accept = 1'b1;
				w.jc     = JC_START;
				w.target = STEP_LOOK;
			end
			STEP_LOOK: begin
				w.look   = 1'b1;
				w.jc     = JC_NOP;
				w.target = STEP_IDLE;
			end
			STEP_UPDATE: begin
				w.update = 1'b1;
				w.emit   = 1'b1;
				w.jc     = JC_ALWAYS;
				w.target = STEP_IDLE;
			end
			default: begin
				w.jc     = JC_ALWAYS;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/rpdt_seq.sv
// ---------------------------------------------------------------------------
// rpdt_seq
// Step counter and control store; conditional jumps on start and no-op code.
// ---------------------------------------------------------------------------
module rpdt_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                is_nop,
	output rpdt_pkg::ctl_word_t ctl
);
	import rpdt_pkg::*;

	step_t step_q;
	step_t step_nxt;

	assign ctl = ucode_rom(step_q);

	always_comb begin
		case (ctl.jc)
			JC_NEXT:   step_nxt = step_q + step_t'(1);
			JC_START:  step_nxt = start ? ctl.target : step_q;
			JC_NOP:    step_nxt = is_nop ? ctl.target : step_q + step_t'(1);
			JC_ALWAYS: step_nxt = ctl.target;
			default:   step_nxt = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

>>> hw/rtl/rpdt_table.sv
// ---------------------------------------------------------------------------
// rpdt_table
// Handle store with parallel port compare, lowest-slot pick and slot update.
// ---------------------------------------------------------------------------
module rpdt_table (
	input  logic            clk,
	input  logic            arst_n,
	input  rpdt_pkg::req_t  req,
	input  logic            look,
	input  logic            update,
	output rpdt_pkg::look_t look_res
);
	import rpdt_pkg::*;

	logic [ENTRIES-1:0] valid_q;
	logic [15:0]        port_q [ENTRIES];
	logic [7:0]         max_q  [ENTRIES];
	logic [ENTRIES-1:0] info_q;
	logic [ENTRIES-1:0] hdl_q;

	look_t look_q;
	look_t srch;
	logic  wr_en;
	logic  clr_en;

	// lowest free and lowest matching slot
	always_comb begin
		srch = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				srch.free_ok  = 1'b1;
				srch.free_idx = idx_t'(i);
			end
			if (valid_q[i] && port_q[i] == req.port) begin
				srch.hit_ok  = 1'b1;
				srch.hit_idx = idx_t'(i);
			end
		end
		srch.hit_max  = max_q[srch.hit_idx];
		srch.hit_info = info_q[srch.hit_idx];
		srch.hit_hdl  = hdl_q[srch.hit_idx];
	end

	always_ff @(posedge clk) begin
		if (look) begin
			look_q <= srch;
		end
	end

	assign look_res = look_q;
	assign wr_en    = update && req.operation == OP_REGISTER && look_q.free_ok;
	assign clr_en   = update && req.operation == OP_DEREGISTER && look_q.hit_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[look_q.free_idx] <= 1'b1;
		end else if (clr_en) begin
			valid_q[look_q.hit_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			port_q[look_q.free_idx] <= req.port;
			max_q[look_q.free_idx]  <= req.max_length;
			info_q[look_q.free_idx] <= req.wants_info;
			hdl_q[look_q.free_idx]  <= req.has_handler;
		end else if (clr_en) begin
			port_q[look_q.hit_idx] <= '0;
		end
	end

endmodule

>>> hw/rtl/receive_port_dispatch_table.sv
// Flow: the idle step accepts a request, the look step registers the search,
// the update step applies table changes and registers result and done; busy is
// high outside idle, and the three-step microprogram takes requests only in idle.
// Operation code 3 returns from the look step to idle and gives no result.
// done lasts one cycle; the receiver cannot stall it.
// Reset: asynchronous, active low; all slots empty, sequencer idle.
// ---------------------------------------------------------------------------
// receive_port_dispatch_table
// Microcoded lookup of receive handles keyed by 16-bit port.
// ---------------------------------------------------------------------------
module receive_port_dispatch_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rpdt_pkg::req_t request,
	output logic           done,
	output rpdt_pkg::rsp_t result
);
	import rpdt_pkg::*;

	ctl_word_t ctl;
	req_t      req_q;
	look_t     look_res;
	rsp_t      res_q;
	rsp_t      res_nxt;
	logic      done_q;

	rpdt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.is_nop (req_q.operation == OP_NONE),
		.ctl    (ctl)
	);

	rpdt_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_q),
		.look     (ctl.look),
		.update   (ctl.update),
		.look_res (look_res)
	);

	assign busy = !ctl.accept;

	always_ff @(posedge clk) begin
		if (ctl.accept && start) begin
			req_q <= request;
		end
	end

	always_comb begin
		res_nxt = '0;
		if (req_q.operation == OP_REGISTER) begin
			if (look_res.free_ok) begin
				res_nxt.slot = SLOT_W'(look_res.free_idx);
			end else begin
				res_nxt.status = ST_FULL;
			end
		end else if (!look_res.hit_ok) begin
			res_nxt.status = ST_NOMATCH;
		end else begin
			res_nxt.slot = SLOT_W'(look_res.hit_idx);
			if (req_q.operation == OP_DELIVER) begin
				res_nxt.copy_length  = (req_q.packet_length > look_res.hit_max) ?
					look_res.hit_max : req_q.packet_length;
				res_nxt.write_info   = look_res.hit_info;
				res_nxt.post_handler = look_res.hit_hdl;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			res_q <= res_nxt;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	// assertions
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but sequencer stayed idle");

	a_done_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ctl.emit) && $past(req_q.operation) != OP_NONE)
		else $error("result strobe without emit step");

	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.slot == '0 &&
			result.copy_length == '0 && !result.write_info && !result.post_handler)
		else $error("failed request carries nonzero fields");

	a_no_done_while_idle_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> busy)
		else $error("emit step while accepting requests");

endmodule
